// File: hdl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// Spindle speed to PWM: shared definitions
// Command codes, register indexes, fixed field widths and the control word
// type used by the bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package ssp_pkg;

    // Fixed field widths.
    localparam int CMD_BITS       = 2;
    localparam int OVR_BITS       = 8;
    localparam int FRAC_BITS      = 16;
    localparam int SLOPE_BITS     = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // The override is a percentage, so the scaled speed is divided by 100.
    localparam int REM_BITS = 7;
    localparam logic [REM_BITS:0] DIVISOR = 8'd100;

    // Spindle command codes.
    localparam logic [CMD_BITS-1:0] CMD_DISABLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_CW      = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CCW     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_PWM_OFF     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PWM_MIN     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PWM_MAX     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED_FLOOR = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED_CEIL  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOPE       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LASER_MODE  = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE_INV  = 3'd7;

    // Control word for a serial unit: load operands, or advance one bit.
    typedef struct packed {
        logic load;
        logic step;
    } ssp_ctl_t;

endpackage

// File: hdl/ssp_serial_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-add multiplier that consumes one bit of the D operand per stepped
// cycle, LSB first, so only a G_BITS+1 wide adder sits between registers.
// ----------------------------------------------------------------------------
module ssp_serial_mul #(
    parameter int D_BITS = 41,
    parameter int G_BITS = 32
) (
    input  logic                     clk,
    input  ssp_pkg::ssp_ctl_t        ctl,
    input  logic [D_BITS-1:0]        d_in,
    input  logic [G_BITS-1:0]        g_in,
    output logic [D_BITS+G_BITS-1:0] product
);
    import ssp_pkg::*;

    logic [D_BITS+G_BITS-1:0] prod_reg;
    logic [D_BITS+G_BITS-1:0] prod_next;
    logic [G_BITS-1:0]        g_reg;
    logic [G_BITS:0]          sum;

    // The upper half accumulates partial products while the lower half
    // shifts out multiplier bits and takes in the low product bits.
    always_comb
    begin
        sum = {1'b0, prod_reg[D_BITS+G_BITS-1:D_BITS]} +
              (prod_reg[0] ? {1'b0, g_reg} : {(G_BITS+1){1'b0}});
        prod_next = prod_reg;
        if (ctl.load)
        begin
            prod_next = {{G_BITS{1'b0}}, d_in};
        end
        else if (ctl.step)
        begin
            prod_next = {sum, prod_reg[D_BITS-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl.load)
        begin
            g_reg <= g_in;
        end
    end

    assign product = prod_reg;

endmodule

// File: hdl/ssp_serial_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divide by 100
// Restoring long division of an N_BITS numerator by the override divisor,
// one quotient bit per stepped cycle, MSB first.
// ----------------------------------------------------------------------------
module ssp_serial_div #(
    parameter int N_BITS = 41
) (
    input  logic              clk,
    input  ssp_pkg::ssp_ctl_t ctl,
    input  logic [N_BITS-1:0] num_in,
    output logic [N_BITS-1:0] quotient
);
    import ssp_pkg::*;

    logic [N_BITS-1:0]   q_reg;
    logic [N_BITS-1:0]   q_next;
    logic [REM_BITS-1:0] rem_reg;
    logic [REM_BITS-1:0] rem_next;
    logic [REM_BITS:0]   trial;
    logic                fits;

    // The remainder stays below the divisor, so one compare and subtract
    // per bit is enough.
    always_comb
    begin
        trial    = {rem_reg, q_reg[N_BITS-1]};
        fits     = (trial >= DIVISOR);
        q_next   = q_reg;
        rem_next = rem_reg;
        if (ctl.load)
        begin
            q_next   = num_in;
            rem_next = '0;
        end
        else if (ctl.step)
        begin
            q_next   = {q_reg[N_BITS-2:0], fits};
            rem_next = fits ? REM_BITS'(trial - DIVISOR) : trial[REM_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign quotient = q_reg;

endmodule

// File: hdl/spindle_speed_to_pwm_control_core.sv
// ----------------------------------------------------------------------------
// Spindle speed to PWM control core
// Turns spindle commands into a held PWM width, enable and direction pin
// levels and a clamped speed report, one result word per command word.
// ----------------------------------------------------------------------------
// One command word is worked at a time. Abort, disable and the unused code
// go from acceptance straight to the finishing state. A run command passes
// through one bit-serial multiplier and one bit-serial divider, each working
// on S = RPM_BITS + 24 bits: rpm times override, a load state, the divide
// by 100 and a range check; a speed inside the linear range then takes the
// slope multiply and a width state, while a speed that is off, at the floor
// or at the ceiling goes straight to the finishing state. A new command
// word is taken while the last result word still waits at the output.
module spindle_speed_to_pwm_control_core #(
    parameter int PWM_BITS = 20,
    parameter int RPM_BITS = 17
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ssp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ssp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ssp_pkg::CMD_BITS-1:0]         cmd,
    input  logic [RPM_BITS-1:0]                  requested_rpm,
    input  logic [ssp_pkg::OVR_BITS-1:0]         override_percent,
    input  logic                                 abort_active,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [PWM_BITS-1:0]                  pwm_width,
    output logic                                 enable_pin,
    output logic                                 direction_pin,
    output logic [RPM_BITS-1:0]                  actual_rpm,
    output logic                                 report_now
);
    import ssp_pkg::*;

    localparam int SCALED_BITS = RPM_BITS + OVR_BITS + FRAC_BITS;
    localparam int PROD_BITS   = SCALED_BITS + SLOPE_BITS;
    localparam int CNT_BITS    = $clog2(SCALED_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(SCALED_BITS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL1   = 3'd1;
    localparam logic [2:0] ST_DLOAD  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_EVAL   = 3'd4;
    localparam logic [2:0] ST_MUL2   = 3'd5;
    localparam logic [2:0] ST_MAPW   = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    localparam logic [1:0] KIND_ABORT   = 2'd0;
    localparam logic [1:0] KIND_HOLD    = 2'd1;
    localparam logic [1:0] KIND_DISABLE = 2'd2;
    localparam logic [1:0] KIND_RUN     = 2'd3;

    // Configuration registers.
    logic [PWM_BITS-1:0]   off_reg;
    logic [PWM_BITS-1:0]   min_reg;
    logic [PWM_BITS-1:0]   max_reg;
    logic [RPM_BITS-1:0]   floor_reg;
    logic [RPM_BITS-1:0]   ceil_reg;
    logic [SLOPE_BITS-1:0] slope_reg;
    logic                  laser_reg;
    logic                  inv_reg;

    // Control and held output state.
    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    logic [1:0]            kind_reg;
    logic                  dir_pend_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PWM_BITS-1:0]   held_width_reg;
    logic                  held_enable_reg;
    logic                  held_dir_reg;
    logic [RPM_BITS-1:0]   held_speed_reg;
    logic                  report_reg;
    logic [PWM_BITS-1:0]   pend_width_reg;
    logic [RPM_BITS-1:0]   pend_speed_reg;

    // Datapath signals.
    logic                   cfg_write;
    logic                   in_accept;
    logic                   is_run;
    logic                   last_step;
    logic                   fin_write;
    logic [RPM_BITS-1:0]    rpm_eff;
    ssp_ctl_t               mul_ctl;
    ssp_ctl_t               div_ctl;
    logic [SCALED_BITS-1:0] mul_d;
    logic [SLOPE_BITS-1:0]  mul_g;
    logic [PROD_BITS-1:0]   product;
    logic [SCALED_BITS-1:0] div_num;
    logic [SCALED_BITS-1:0] quotient_w;
    logic [SCALED_BITS-1:0] scaled;
    logic [SCALED_BITS-1:0] lo_ext;
    logic [SCALED_BITS-1:0] hi_ext;
    logic                   zero_case;
    logic                   floor_case;
    logic                   ceil_case;
    logic                   lin_case;
    logic [PWM_BITS-1:0]    max_less_one;
    logic [SCALED_BITS:0]   width_sum;
    logic                   width_sat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= PWM_BITS'(1000);
            floor_reg <= '0;
            ceil_reg  <= RPM_BITS'(1000);
            slope_reg <= SLOPE_BITS'(65536);
            laser_reg <= 1'b0;
            inv_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PWM_OFF:     off_reg   <= cfg_data[PWM_BITS-1:0];
                REG_PWM_MIN:     min_reg   <= cfg_data[PWM_BITS-1:0];
                REG_PWM_MAX:     max_reg   <= cfg_data[PWM_BITS-1:0];
                REG_SPEED_FLOOR: floor_reg <= cfg_data[RPM_BITS-1:0];
                REG_SPEED_CEIL:  ceil_reg  <= cfg_data[RPM_BITS-1:0];
                REG_SLOPE:       slope_reg <= cfg_data[SLOPE_BITS-1:0];
                REG_LASER_MODE:  laser_reg <= cfg_data[0];
                REG_ENABLE_INV:  inv_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Input side: one command word at a time.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign is_run    = (cmd == CMD_CW) || (cmd == CMD_CCW);
    assign rpm_eff   = (laser_reg && (cmd == CMD_CCW)) ? '0 : requested_rpm;
    assign last_step = (cnt_reg == LAST_STEP);
    assign fin_write = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // Range check on the scaled speed, unsigned with 16 fraction bits (Q25.16 at RPM_BITS = 17).
    assign scaled     = quotient_w;
    assign lo_ext     = {{OVR_BITS{1'b0}}, floor_reg, {FRAC_BITS{1'b0}}};
    assign hi_ext     = {{OVR_BITS{1'b0}}, ceil_reg, {FRAC_BITS{1'b0}}};
    assign zero_case  = (scaled == '0);
    assign floor_case = (scaled <= lo_ext);
    assign ceil_case  = (scaled >= hi_ext);
    assign lin_case   = !zero_case && !floor_case && !ceil_case;

    // Saturated width and the linear width from the slope product.
    assign max_less_one = (max_reg == '0) ? '0 : max_reg - 1'b1;
    assign width_sum    = {1'b0, product[PROD_BITS-1:SLOPE_BITS]} +
                          {{(SCALED_BITS+1-PWM_BITS){1'b0}}, min_reg};
    assign width_sat    = (width_sum >= {{(SCALED_BITS+1-PWM_BITS){1'b0}}, max_reg});

    // The multiplier first forms rpm times override, then the slope product.
    always_comb
    begin
        mul_ctl.load = (in_accept && is_run && !abort_active) ||
                       ((state_reg == ST_EVAL) && lin_case);
        mul_ctl.step = (state_reg == ST_MUL1) || (state_reg == ST_MUL2);
        if (state_reg == ST_IDLE)
        begin
            mul_d = {{(SCALED_BITS-OVR_BITS){1'b0}}, override_percent};
            mul_g = {{(SLOPE_BITS-RPM_BITS){1'b0}}, rpm_eff};
        end
        else
        begin
            mul_d = scaled - lo_ext;
            mul_g = slope_reg;
        end
        div_ctl.load = (state_reg == ST_DLOAD);
        div_ctl.step = (state_reg == ST_DIV);
        div_num      = {product[RPM_BITS+OVR_BITS-1:0], {FRAC_BITS{1'b0}}};
    end

    ssp_serial_mul #(
        .D_BITS (SCALED_BITS),
        .G_BITS (SLOPE_BITS)
    ) u_mul (
        .clk     (clk),
        .ctl     (mul_ctl),
        .d_in    (mul_d),
        .g_in    (mul_g),
        .product (product)
    );

    ssp_serial_div #(
        .N_BITS (SCALED_BITS)
    ) u_div (
        .clk      (clk),
        .ctl      (div_ctl),
        .num_in   (div_num),
        .quotient (quotient_w)
    );

    // Sequencer for the serial arithmetic.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (is_run && !abort_active) ? ST_MUL1 : ST_FINISH;
                end
            end
            ST_MUL1:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    cnt_next   = '0;
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    cnt_next   = '0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = lin_case ? ST_MUL2 : ST_FINISH;
            end
            ST_MUL2:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    cnt_next   = '0;
                    state_next = ST_MAPW;
                end
            end
            ST_MAPW:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (fin_write)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid: set when a result is written, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            kind_reg        <= KIND_ABORT;
            dir_pend_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            held_width_reg  <= '0;
            held_enable_reg <= 1'b0;
            held_dir_reg    <= 1'b0;
            held_speed_reg  <= '0;
            report_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                dir_pend_reg <= (cmd == CMD_CCW);
                if (abort_active)
                begin
                    kind_reg <= KIND_ABORT;
                end
                else if (cmd == CMD_DISABLE)
                begin
                    kind_reg <= KIND_DISABLE;
                end
                else if (is_run)
                begin
                    kind_reg <= KIND_RUN;
                end
                else
                begin
                    kind_reg <= KIND_HOLD;
                end
            end
            if (fin_write)
            begin
                report_reg <= (kind_reg != KIND_ABORT);
                case (kind_reg)
                    KIND_DISABLE:
                    begin
                        held_width_reg  <= '0;
                        held_speed_reg  <= '0;
                        held_enable_reg <= inv_reg;
                    end
                    KIND_RUN:
                    begin
                        held_width_reg  <= pend_width_reg;
                        held_speed_reg  <= pend_speed_reg;
                        held_dir_reg    <= dir_pend_reg;
                        held_enable_reg <= !inv_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Width and speed chosen by the range check, or by the slope product.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            if (zero_case)
            begin
                pend_width_reg <= off_reg;
                pend_speed_reg <= '0;
            end
            else if (floor_case)
            begin
                pend_width_reg <= min_reg;
                pend_speed_reg <= floor_reg;
            end
            else if (ceil_case)
            begin
                pend_width_reg <= max_less_one;
                pend_speed_reg <= ceil_reg;
            end
            else
            begin
                pend_speed_reg <= scaled[RPM_BITS+FRAC_BITS-1:FRAC_BITS];
            end
        end
        else if (state_reg == ST_MAPW)
        begin
            pend_width_reg <= width_sat ? max_less_one : width_sum[PWM_BITS-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign pwm_width     = held_width_reg;
    assign enable_pin    = held_enable_reg;
    assign direction_pin = held_dir_reg;
    assign actual_rpm    = held_speed_reg;
    assign report_now    = report_reg;

`ifndef SYNTHESIS
    // An aborted command leaves every held output as it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_write && (kind_reg == KIND_ABORT)) |=>
        (!report_now && $stable(pwm_width) && $stable(actual_rpm) &&
         $stable(direction_pin) && $stable(enable_pin)))
        else $error("aborted command changed the held outputs");

    // A disable command clears the width and the reported speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_write && (kind_reg == KIND_DISABLE)) |=>
        ((pwm_width == '0) && (actual_rpm == '0) && report_now))
        else $error("disable command did not clear width and speed");

    // A result word only appears after the finishing step of the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result word raised outside the finishing step");
`endif

endmodule
